// File: src/cdq_pkg.sv
package cdq_pkg;

    localparam int DATA_W      = 32;
    localparam int DEPTH_DEF   = 8;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // one-hot operation broadcast to every cell, only for granted transactions
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } t_cell_ctrl;

endpackage

// File: src/cdq_cell.sv
module cdq_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cdq_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_push_value,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_left_value,
    input  logic                                i_left_valid,
    input  logic signed [cdq_pkg::DATA_W-1:0]   i_right_value,
    input  logic                                i_right_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_value,
    output logic                                o_valid,
    output logic signed [cdq_pkg::DATA_W-1:0]   o_rear_tap
);

    logic signed [cdq_pkg::DATA_W-1:0] r_value;
    logic signed [cdq_pkg::DATA_W-1:0] n_value;
    logic                              r_valid;
    logic                              n_valid;
    logic                              w_is_rear;
    logic                              w_first_empty;

    assign w_is_rear     = r_valid && !i_right_valid;
    assign w_first_empty = !r_valid && i_left_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        priority if (i_ctrl.push_front) begin
            // whole row shifts toward the rear
            n_value = i_left_value;
            n_valid = i_left_valid;
        end else if (i_ctrl.push_rear) begin
            if (w_first_empty) begin
                n_value = i_push_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.pop_front) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.pop_rear) begin
            if (w_is_rear) begin
                n_valid = 1'b0;
            end
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value    = r_value;
    assign o_valid    = r_valid;
    assign o_rear_tap = w_is_rear ? r_value : '0;

endmodule

// File: src/circular_deque.sv
// the result strobe o_done is registered and comes in the cycle after start is taken
// throughput: one transaction per cycle, busy stays low; every cell updates
// in the same cycle, and the rear value is an and-or over the row of cells
// reset: synchronous active low, clears occupancy, cell valid bits and the
// result strobe; stored element data is not cleared
// the receiver cannot stall, each result is shown for exactly one cycle
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       start,
    output logic                                       busy,
    input  logic [cdq_pkg::ACTION_W-1:0]               i_action,
    input  logic signed [cdq_pkg::DATA_W-1:0]          i_value,
    output logic                                       o_done,
    output logic signed [cdq_pkg::DATA_W-1:0]          o_data,
    output logic [cdq_pkg::STATUS_W-1:0]               o_status,
    output logic [$clog2(DEPTH+1)-1:0]                 o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]                       r_count;
    logic [CW-1:0]                       n_count;
    logic                                r_done;
    logic signed [cdq_pkg::DATA_W-1:0]   r_data;
    logic signed [cdq_pkg::DATA_W-1:0]   n_data;
    cdq_pkg::t_status                    r_status;
    cdq_pkg::t_status                    n_status;
    cdq_pkg::t_cell_ctrl                 w_ctrl;
    cdq_pkg::t_action                    w_action;
    logic                                w_accept;
    logic                                w_full;
    logic                                w_empty;
    logic signed [cdq_pkg::DATA_W-1:0]   w_rear_data;

    logic signed [cdq_pkg::DATA_W-1:0]   w_value [DEPTH];
    logic                                w_valid [DEPTH];
    logic signed [cdq_pkg::DATA_W-1:0]   w_tap   [DEPTH];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_action = cdq_pkg::t_action'(i_action);
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_rear_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_data = w_rear_data | w_tap[i];
        end
    end

    always_comb begin
        w_ctrl   = '0;
        n_count  = r_count;
        n_data   = '0;
        n_status = cdq_pkg::ST_OK;
        if (w_accept) begin
            unique case (w_action)
                cdq_pkg::ACT_PUSH_FRONT,
                cdq_pkg::ACT_PUSH_REAR: begin
                    if (w_full) begin
                        n_status = cdq_pkg::ST_OVERFLOW;
                    end else begin
                        w_ctrl.push_front = (w_action == cdq_pkg::ACT_PUSH_FRONT);
                        w_ctrl.push_rear  = (w_action == cdq_pkg::ACT_PUSH_REAR);
                        n_count = r_count + CW'(1);
                    end
                end
                cdq_pkg::ACT_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = cdq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_ctrl.pop_front = 1'b1;
                        n_data  = w_value[0];
                        n_count = r_count - CW'(1);
                    end
                end
                cdq_pkg::ACT_POP_REAR: begin
                    if (w_empty) begin
                        n_status = cdq_pkg::ST_UNDERFLOW;
                    end else begin
                        w_ctrl.pop_rear = 1'b1;
                        n_data  = w_rear_data;
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = cdq_pkg::ST_OK;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [cdq_pkg::DATA_W-1:0] w_lv;
            logic                              w_lok;
            logic signed [cdq_pkg::DATA_W-1:0] w_rv;
            logic                              w_rok;

            // the front end sees the incoming value as an always-valid neighbor
            if (g == 0) begin : g_head
                assign w_lv  = i_value;
                assign w_lok = 1'b1;
            end else begin : g_mid_l
                assign w_lv  = w_value[g-1];
                assign w_lok = w_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_rv  = '0;
                assign w_rok = 1'b0;
            end else begin : g_mid_r
                assign w_rv  = w_value[g+1];
                assign w_rok = w_valid[g+1];
            end

            cdq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_push_value  (i_value),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lok),
                .i_right_value (w_rv),
                .i_right_valid (w_rok),
                .o_value       (w_value[g]),
                .o_valid       (w_valid[g]),
                .o_rear_tap    (w_tap[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_status <= n_status;
    end

    assign o_done      = r_done;
    assign o_data      = r_data;
    assign o_status    = r_status;
    assign o_occupancy = r_count;

endmodule

// File: dv/cdq_checker.sv
module cdq_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic [ACTION_W-1:0]               i_action,
    input  logic signed [DATA_W-1:0]          i_value,
    input  logic                              i_done,
    input  logic signed [DATA_W-1:0]          i_data,
    input  logic [STATUS_W-1:0]               i_status,
    input  logic [$clog2(DEPTH+1)-1:0]        i_occupancy,
    output int                                o_err_count,
    output int                                o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OCC_W = $clog2(DEPTH+1);

    typedef struct {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
    } t_deque_result;

    logic [DATA_W-1:0] ring_model [DEPTH];
    int                head_idx;
    int                tail_idx;
    int                elem_count;
    t_deque_result     predicted_results [$];

    function automatic t_deque_result apply_deque_op(t_action act, logic [DATA_W-1:0] val);
        t_deque_result res;
        res.data   = '0;
        res.status = ST_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (elem_count >= DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    // first element always lands in entry 0
                    if (elem_count == 0) begin
                        head_idx = 0;
                        tail_idx = 0;
                        ring_model[0] = val;
                    end else if (act == ACT_PUSH_FRONT) begin
                        head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                        ring_model[head_idx] = val;
                    end else begin
                        tail_idx = (tail_idx + 1 >= DEPTH) ? 0 : tail_idx + 1;
                        ring_model[tail_idx] = val;
                    end
                    elem_count++;
                end
            end
            default: begin
                if (elem_count == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    if (act == ACT_POP_FRONT) begin
                        res.data = ring_model[head_idx];
                        head_idx = (head_idx + 1 >= DEPTH) ? 0 : head_idx + 1;
                    end else begin
                        res.data = ring_model[tail_idx];
                        tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                    end
                    elem_count--;
                    if (elem_count == 0) begin
                        head_idx = 0;
                        tail_idx = 0;
                    end
                end
            end
        endcase
        res.occupancy = OCC_W'(elem_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_deque_result want;
        if (!i_rst_n) begin
            head_idx    = 0;
            tail_idx    = 0;
            elem_count  = 0;
            o_err_count = 0;
            predicted_results.delete();
        end else begin
            if (i_start && !i_busy)
                predicted_results.push_back(apply_deque_op(t_action'(i_action), i_value));
            if (i_done) begin
                if (predicted_results.size() == 0) begin
                    o_err_count++;
                    $display("%0t unexpected result: data %0d status %0d occupancy %0d",
                             $time, i_data, i_status, i_occupancy);
                end else begin
                    want = predicted_results.pop_front();
                    if (i_data !== want.data) begin
                        o_err_count++;
                        $display("%0t data mismatch: expected %0d actual %0d",
                                 $time, want.data, i_data);
                    end
                    if (i_status !== want.status) begin
                        o_err_count++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_status);
                    end
                    if (i_occupancy !== want.occupancy) begin
                        o_err_count++;
                        $display("%0t occupancy mismatch: expected %0d actual %0d",
                                 $time, want.occupancy, i_occupancy);
                    end
                end
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

// File: dv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH       = 8;
    localparam int OCC_W       = $clog2(DEPTH+1);
    localparam int N_RANDOM    = 1250;
    localparam int CYCLE_LIMIT = 100000;

    // operation mix of the random part
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_EVEN    = 2;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [ACTION_W-1:0]      i_action;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_done;
    logic signed [DATA_W-1:0] o_data;
    logic [STATUS_W-1:0]      o_status;
    logic [OCC_W-1:0]         o_occupancy;
    int                       err_count;
    int                       pending;
    int                       cycle_count = 0;

    circular_deque #(.DEPTH(DEPTH)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    cdq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_done      (o_done),
        .i_data      (o_data),
        .i_status    (o_status),
        .i_occupancy (o_occupancy),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // holds start high until the transaction is taken
    task automatic send_op(input t_action act, input logic [DATA_W-1:0] val);
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // start low, with junk on the payload that must be ignored
    task automatic idle_gap(input int n);
        start <= 1'b0;
        repeat (n) begin
            @(posedge i_clk);
            i_action <= ACTION_W'($urandom);
            i_value  <= $urandom;
        end
    endtask

    function automatic t_action pick_action(input int mix);
        int  roll;
        logic push;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  push = (roll < 75);
            MIX_DRAIN: push = (roll < 25);
            default:   push = (roll < 50);
        endcase
        if (push)
            return ($urandom_range(0, 1) != 0) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
        return ($urandom_range(0, 1) != 0) ? ACT_POP_REAR : ACT_POP_FRONT;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n_items;
        int burst_left;
        int mix;
        int mix_left;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_action    = ACT_PUSH_FRONT;
        i_value     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue pops, single element round trip
        send_op(ACT_POP_FRONT,  32'h1111_1111);
        send_op(ACT_POP_REAR,   32'h2222_2222);
        send_op(ACT_PUSH_FRONT, 32'h8000_0000);
        send_op(ACT_POP_REAR,   32'h0);
        send_op(ACT_PUSH_REAR,  32'h7fff_ffff);
        send_op(ACT_POP_FRONT,  32'h0);
        // fill to full from both ends, wrapping the front index
        send_op(ACT_PUSH_REAR,  32'h7fff_ffff);
        send_op(ACT_PUSH_FRONT, 32'hffff_ffff);
        send_op(ACT_PUSH_REAR,  32'h0000_0000);
        send_op(ACT_PUSH_FRONT, 32'h0000_0001);
        send_op(ACT_PUSH_REAR,  32'h5555_5555);
        send_op(ACT_PUSH_FRONT, 32'haaaa_aaaa);
        send_op(ACT_PUSH_REAR,  32'h1234_5678);
        send_op(ACT_PUSH_FRONT, 32'h8000_0000);
        // pushes to a full queue are refused
        send_op(ACT_PUSH_FRONT, 32'hdead_beef);
        send_op(ACT_PUSH_REAR,  32'hcafe_f00d);
        // drain alternately down to empty and past it
        repeat (4) begin
            send_op(ACT_POP_FRONT, 32'h0);
            send_op(ACT_POP_REAR,  32'h0);
        end
        send_op(ACT_POP_REAR,  32'h0);

        n_items    = 0;
        burst_left = 0;
        mix_left   = 0;
        mix        = MIX_EVEN;
        while (n_items < N_RANDOM) begin
            if (mix_left == 0) begin
                mix      = $urandom_range(MIX_FILL, MIX_EVEN);
                mix_left = $urandom_range(8, 40);
            end
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    idle_gap($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
            send_op(pick_action(mix), pick_value());
            n_items++;
            burst_left--;
            mix_left--;
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
